// ----- rtl/nrfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrfs_pkg
// Shared types and constants for the nearest-return follow steering block.
// ----------------------------------------------------------------------------
package nrfs_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int ADDR_W          = 5;

    // Register indexes on the APB port; register i sits at byte address 4*i.
    typedef enum logic [2:0] {
        REG_RANGE_LOWER   = 3'd0,
        REG_RANGE_UPPER   = 3'd1,
        REG_START_ANGLE   = 3'd2,
        REG_ANGLE_STEP    = 3'd3,
        REG_STOP_DISTANCE = 3'd4,
        REG_LINEAR_GAIN   = 3'd5,
        REG_ANGULAR_GAIN  = 3'd6
    } t_reg_idx;

    // Kind of steering command carried by a result transaction.
    typedef enum logic [1:0] {
        KIND_STOP   = 2'd0,
        KIND_ROTATE = 2'd1,
        KIND_DRIVE  = 2'd2
    } t_kind;

    // Register file contents as seen by the datapath.
    typedef struct packed {
        logic [15:0]        range_lower;
        logic [15:0]        range_upper;
        logic signed [19:0] start_angle;
        logic [15:0]        angle_step;
        logic [15:0]        stop_distance;
        logic [15:0]        linear_gain;
        logic [15:0]        angular_gain;
    } t_cfg;

    // Hand-off from the scan tracker to the command unit at scan end.
    typedef struct packed {
        logic start;
        logic found;
    } t_launch;

endpackage

// ----- rtl/nrfs_apb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrfs_apb
// APB register file holding the steering configuration.
// ----------------------------------------------------------------------------
module nrfs_apb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nrfs_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output nrfs_pkg::t_cfg                o_cfg
);

    localparam logic [15:0]        RST_RANGE_LOWER   = 16'd0;
    localparam logic [15:0]        RST_RANGE_UPPER   = 16'd65535;
    localparam logic signed [19:0] RST_START_ANGLE   = -20'sd205887;
    localparam logic [15:0]        RST_ANGLE_STEP    = 16'd1144;
    localparam logic [15:0]        RST_STOP_DISTANCE = 16'd1000;
    localparam logic [15:0]        RST_LINEAR_GAIN   = 16'd1311;
    localparam logic [15:0]        RST_ANGULAR_GAIN  = 16'd5243;

    nrfs_pkg::t_cfg     r_cfg;
    nrfs_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign w_idx  = nrfs_pkg::t_reg_idx'(paddr[nrfs_pkg::ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_lower   <= RST_RANGE_LOWER;
            r_cfg.range_upper   <= RST_RANGE_UPPER;
            r_cfg.start_angle   <= RST_START_ANGLE;
            r_cfg.angle_step    <= RST_ANGLE_STEP;
            r_cfg.stop_distance <= RST_STOP_DISTANCE;
            r_cfg.linear_gain   <= RST_LINEAR_GAIN;
            r_cfg.angular_gain  <= RST_ANGULAR_GAIN;
        end else if (w_wr) begin
            case (w_idx)
                nrfs_pkg::REG_RANGE_LOWER:   r_cfg.range_lower   <= pwdata[15:0];
                nrfs_pkg::REG_RANGE_UPPER:   r_cfg.range_upper   <= pwdata[15:0];
                nrfs_pkg::REG_START_ANGLE:   r_cfg.start_angle   <= pwdata[19:0];
                nrfs_pkg::REG_ANGLE_STEP:    r_cfg.angle_step    <= pwdata[15:0];
                nrfs_pkg::REG_STOP_DISTANCE: r_cfg.stop_distance <= pwdata[15:0];
                nrfs_pkg::REG_LINEAR_GAIN:   r_cfg.linear_gain   <= pwdata[15:0];
                nrfs_pkg::REG_ANGULAR_GAIN:  r_cfg.angular_gain  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            nrfs_pkg::REG_RANGE_LOWER:   prdata = {16'h0, r_cfg.range_lower};
            nrfs_pkg::REG_RANGE_UPPER:   prdata = {16'h0, r_cfg.range_upper};
            nrfs_pkg::REG_START_ANGLE:   prdata = {{12{r_cfg.start_angle[19]}},
                                                   r_cfg.start_angle};
            nrfs_pkg::REG_ANGLE_STEP:    prdata = {16'h0, r_cfg.angle_step};
            nrfs_pkg::REG_STOP_DISTANCE: prdata = {16'h0, r_cfg.stop_distance};
            nrfs_pkg::REG_LINEAR_GAIN:   prdata = {16'h0, r_cfg.linear_gain};
            nrfs_pkg::REG_ANGULAR_GAIN:  prdata = {16'h0, r_cfg.angular_gain};
            default:                     prdata = 32'h0;
        endcase
    end

endmodule

// ----- rtl/nrfs_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrfs_scan
// Streaming tracker of the nearest in-window range sample of one scan.
// ----------------------------------------------------------------------------
module nrfs_scan #(
    parameter int MAX_SAMPLES = nrfs_pkg::MAX_SAMPLES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [15:0]                    i_range_sample,
    input  logic                           i_last_sample,
    input  nrfs_pkg::t_cfg                 i_cfg,
    input  logic                           i_busy,
    output nrfs_pkg::t_launch              o_launch,
    output logic [15:0]                    o_best_range,
    output logic [$clog2(MAX_SAMPLES)-1:0] o_best_pos
);

    localparam int IW = $clog2(MAX_SAMPLES);
    localparam int PW = $clog2(MAX_SAMPLES + 1);

    logic [15:0]   r_best_range;
    logic [IW-1:0] r_best_pos;
    logic [PW-1:0] r_pos;
    logic          r_found;

    logic [15:0]   n_best_range;
    logic [IW-1:0] n_best_pos;
    logic          n_found;
    logic          w_accept;
    logic          w_hit;

    // Only the closing sample has to wait for the command unit.
    assign o_stall  = i_last_sample & i_busy;
    assign w_accept = i_valid & ~o_stall;

    assign w_hit = (r_pos < PW'(MAX_SAMPLES))
                && (i_range_sample > i_cfg.range_lower)
                && (i_range_sample < i_cfg.range_upper)
                && (!r_found || (i_range_sample < r_best_range));

    always_comb begin
        n_best_range = r_best_range;
        n_best_pos   = r_best_pos;
        n_found      = r_found;
        if (w_hit) begin
            n_best_range = i_range_sample;
            n_best_pos   = r_pos[IW-1:0];
            n_found      = 1'b1;
        end
    end

    assign o_launch.start = w_accept & i_last_sample;
    assign o_launch.found = n_found;
    assign o_best_range   = n_best_range;
    assign o_best_pos     = n_best_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_range <= '0;
            r_best_pos   <= '0;
            r_pos        <= '0;
            r_found      <= 1'b0;
        end else if (w_accept) begin
            if (i_last_sample) begin
                r_best_range <= '0;
                r_best_pos   <= '0;
                r_pos        <= '0;
                r_found      <= 1'b0;
            end else begin
                r_best_range <= n_best_range;
                r_best_pos   <= n_best_pos;
                r_found      <= n_found;
                if (r_pos < PW'(MAX_SAMPLES)) begin
                    r_pos <= r_pos + PW'(1);
                end
            end
        end
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(MAX_SAMPLES))
        else $error("sample position ran past the scan limit");

    a_scan_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last_sample) |=> (r_pos == '0 && !r_found))
        else $error("scan state not cleared after the closing sample");

endmodule

// ----- rtl/nrfs_cmd.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrfs_cmd
// Bit-serial command unit: turn angle, angular speed and linear speed.
// ----------------------------------------------------------------------------
module nrfs_cmd #(
    parameter int MAX_SAMPLES = nrfs_pkg::MAX_SAMPLES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  nrfs_pkg::t_cfg                 i_cfg,
    input  nrfs_pkg::t_launch              i_launch,
    input  logic [15:0]                    i_best_range,
    input  logic [$clog2(MAX_SAMPLES)-1:0] i_best_pos,
    output logic                           o_busy,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [23:0]                    o_linear_speed,
    output logic signed [23:0]             o_angular_speed,
    output logic [1:0]                     o_command_kind,
    output logic [9:0]                     o_nearest_index
);

    localparam int IW     = $clog2(MAX_SAMPLES);
    localparam int PROD_W = 16 + IW;
    // The start angle plus the product can carry one bit past the wider term.
    localparam int TURN_W = ((PROD_W > 20) ? PROD_W : 20) + 2;
    localparam int MAG_W  = TURN_W - 1;
    localparam int ACC_W  = MAG_W + 16;
    localparam int NUM_W  = ((MAG_W - 1 > 32) ? (MAG_W - 1) : 32) + 1;
    localparam int AM_W   = (MAG_W > 24) ? MAG_W : 25;
    localparam int CNT_W  = $clog2(NUM_W);

    localparam logic [23:0]     LIN_MAX = 24'hFFFFFF;
    localparam logic [23:0]     ANG_MAX = 24'h7FFFFF;
    localparam logic [23:0]     ANG_MIN = 24'h800000;
    localparam logic [AM_W-1:0] AM_LIM  = AM_W'(24'h800000);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MPOS,
        S_TURN,
        S_MGAIN,
        S_ANG,
        S_DIV,
        S_LIN
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_mcand;
    logic [15:0]      r_mplier;
    logic             r_neg;
    logic [MAG_W-1:0] r_mag;
    logic [NUM_W-1:0] r_num;
    logic [MAG_W-1:0] r_rem;
    logic [15:0]      r_best_range;
    logic [IW-1:0]    r_best_pos;
    logic             r_out_valid;
    logic [23:0]      r_lin;
    logic [23:0]      r_ang;
    nrfs_pkg::t_kind  r_kind;
    logic [9:0]       r_idx;

    logic [ACC_W-1:0]  w_sum;
    logic [TURN_W-1:0] w_turn;
    logic [TURN_W-1:0] w_turn_abs;
    logic [ACC_W-1:0]  w_rnd;
    logic [AM_W-1:0]   w_am;
    logic [AM_W-1:0]   w_am_neg;
    logic [23:0]       w_ang;
    logic [NUM_W-1:0]  w_num;
    logic [MAG_W:0]    w_trial;
    logic [MAG_W:0]    w_diff;
    logic              w_ge;

    // Shift-add multiplier: one multiplier bit per cycle.
    assign w_sum = r_acc + r_mcand;

    assign w_turn = {{(TURN_W - 20){i_cfg.start_angle[19]}}, i_cfg.start_angle}
                  + {1'b0, r_acc[MAG_W-1:0]};
    assign w_turn_abs = w_turn[TURN_W-1] ? (~w_turn + TURN_W'(1)) : w_turn;

    // Round half away from zero on the magnitude, then restore the sign.
    assign w_rnd    = r_acc + ACC_W'(32768);
    assign w_am     = AM_W'(w_rnd[ACC_W-1:16]);
    assign w_am_neg = ~w_am + AM_W'(1);

    always_comb begin
        if (r_neg) begin
            w_ang = (w_am > AM_LIM) ? ANG_MIN : w_am_neg[23:0];
        end else begin
            w_ang = (w_am >= AM_LIM) ? ANG_MAX : w_am[23:0];
        end
    end

    // Half the divisor is added up front so the quotient rounds to nearest.
    assign w_num = NUM_W'({i_cfg.linear_gain, 16'h0}) + NUM_W'(r_mag >> 1);

    // Restoring divider: one quotient bit per cycle, shifted into r_num.
    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_mag});
    assign w_diff  = w_trial - {1'b0, r_mag};

    assign o_busy          = (r_state != S_IDLE) || r_out_valid;
    assign o_valid         = r_out_valid;
    assign o_linear_speed  = r_lin;
    assign o_angular_speed = r_ang;
    assign o_command_kind  = r_kind;
    assign o_nearest_index = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_kind      <= nrfs_pkg::KIND_STOP;
            r_lin       <= '0;
            r_ang       <= '0;
            r_idx       <= '0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_launch.start) begin
                        r_best_range <= i_best_range;
                        r_best_pos   <= i_best_pos;
                        if (i_launch.found) begin
                            r_acc    <= '0;
                            r_mcand  <= ACC_W'(i_cfg.angle_step);
                            r_mplier <= 16'(i_best_pos);
                            r_cnt    <= CNT_W'(IW - 1);
                            r_state  <= S_MPOS;
                        end else begin
                            r_lin       <= '0;
                            r_ang       <= '0;
                            r_kind      <= nrfs_pkg::KIND_STOP;
                            r_idx       <= '0;
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                S_MPOS, S_MGAIN: begin
                    if (r_mplier[0]) begin
                        r_acc <= w_sum;
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= (r_state == S_MPOS) ? S_TURN : S_ANG;
                    end
                end
                S_TURN: begin
                    r_neg    <= w_turn[TURN_W-1];
                    r_mag    <= w_turn_abs[MAG_W-1:0];
                    r_acc    <= '0;
                    r_mcand  <= ACC_W'(w_turn_abs[MAG_W-1:0]);
                    r_mplier <= i_cfg.angular_gain;
                    r_cnt    <= CNT_W'(15);
                    r_state  <= S_MGAIN;
                end
                S_ANG: begin
                    r_ang <= w_ang;
                    r_idx <= 10'(r_best_pos);
                    if (r_best_range <= i_cfg.stop_distance) begin
                        r_kind      <= nrfs_pkg::KIND_ROTATE;
                        r_lin       <= '0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (r_mag == '0) begin
                        r_kind      <= nrfs_pkg::KIND_DRIVE;
                        r_lin       <= LIN_MAX;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_kind  <= nrfs_pkg::KIND_DRIVE;
                        r_num   <= w_num;
                        r_rem   <= '0;
                        r_cnt   <= CNT_W'(NUM_W - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_diff[MAG_W-1:0] : w_trial[MAG_W-1:0];
                    r_num <= {r_num[NUM_W-2:0], w_ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_LIN;
                    end
                end
                S_LIN: begin
                    r_lin       <= (r_num > NUM_W'(LIN_MAX)) ? LIN_MAX : r_num[23:0];
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_out_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_IDLE))
        else $error("result presented while the command unit is still working");

    a_no_launch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_launch.start |-> !o_busy)
        else $error("scan end launched into a busy command unit");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == nrfs_pkg::KIND_STOP)
            |-> (r_lin == '0 && r_ang == '0 && r_idx == '0))
        else $error("stop command carries nonzero fields");

endmodule

// ----- rtl/nearest_return_follow_steering.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_return_follow_steering
// Follows the nearest laser return: one steering command per scan.
// ----------------------------------------------------------------------------
// Throughput: one range sample per cycle; the closing sample of a scan waits
// only while the previous scan's command is still being computed or held.
// After the closing sample a stop command is presented in the next cycle. Rotate and
// drive pass the bit-serial multiplier twice (position by angle step, then turn by
// angular gain); a nonzero-turn drive adds the one-bit-per-cycle restoring divider.
// Reset (synchronous, active low) clears the scan state and loads default registers.
module nearest_return_follow_steering #(
    parameter int MAX_SAMPLES = nrfs_pkg::MAX_SAMPLES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [15:0]                 i_range_sample,
    input  logic                        i_last_sample,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [23:0]                 o_linear_speed,
    output logic signed [23:0]          o_angular_speed,
    output logic [1:0]                  o_command_kind,
    output logic [9:0]                  o_nearest_index,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nrfs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int IW = $clog2(MAX_SAMPLES);

    nrfs_pkg::t_cfg    w_cfg;
    nrfs_pkg::t_launch w_launch;
    logic [15:0]       w_best_range;
    logic [IW-1:0]     w_best_pos;
    logic              w_busy;

    nrfs_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    nrfs_scan #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_range_sample (i_range_sample),
        .i_last_sample  (i_last_sample),
        .i_cfg          (w_cfg),
        .i_busy         (w_busy),
        .o_launch       (w_launch),
        .o_best_range   (w_best_range),
        .o_best_pos     (w_best_pos)
    );

    nrfs_cmd #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_cmd (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_launch        (w_launch),
        .i_best_range    (w_best_range),
        .i_best_pos      (w_best_pos),
        .o_busy          (w_busy),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_linear_speed  (o_linear_speed),
        .o_angular_speed (o_angular_speed),
        .o_command_kind  (o_command_kind),
        .o_nearest_index (o_nearest_index)
    );

endmodule
